/* rtl/ita_pkg.sv */
// Package for the integer to ASCII formatter: word types, command codes, states, helpers.
`timescale 1ns / 1ps
package ita_pkg;

	// Command codes
	localparam logic [2:0] CMD_SDEC   = 3'd0;
	localparam logic [2:0] CMD_UDEC   = 3'd1;
	localparam logic [2:0] CMD_HEX_LO = 3'd2;
	localparam logic [2:0] CMD_HEX_UP = 3'd3;
	localparam logic [2:0] CMD_PTR_LO = 3'd4;
	localparam logic [2:0] CMD_PTR_UP = 3'd5;

	// Sizes
	localparam int VALUE_W  = 64;
	localparam int DEC_W    = 32;
	localparam int NIBBLES  = VALUE_W / 4;
	localparam int BCD_DIGS = 10;
	localparam int CNT_W    = $clog2(DEC_W);
	localparam int NDIG_W   = $clog2(NIBBLES + 1);

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	typedef struct packed {
		logic [2:0]         command;
		logic [VALUE_W-1:0] value;
		logic               plus_flag;
	} ita_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} ita_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_PREFIX,
		ST_DIGITS
	} ita_state_t;

	// One nibble to its ASCII digit
	function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib, input logic upper);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else if (upper) begin
			ch = CH_UP_A + {4'd0, nib} - 8'd10;
		end else begin
			ch = CH_LO_A + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

endpackage

/* rtl/integer_to_ascii_formatter.sv */
// Top level: serial integer to decimal/hex ASCII formatter.
// Operation: a word is accepted in idle. Hex modes then scan the 16 nibbles for the first nonzero
// one, emit the prefix, then one character per cycle while the output is not stalled.
// Decimal modes first run shift-and-add-3 BCD conversion, one bit per cycle.
// A new word is not taken while one is being formatted; the next word is accepted once the last
// character has been loaded into the output register.
// Reset (arst_n low) returns the controller to idle and drops the output valid.
`timescale 1ns / 1ps
module integer_to_ascii_formatter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ita_pkg::ita_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ita_pkg::ita_out_t out_data
);
	import ita_pkg::*;

	ita_state_t state_q, state_d;

	logic [VALUE_W-1:0] dig_q;    // digit shift register, top nibble is next
	logic [DEC_W-1:0]   bin_q;    // binary source for BCD conversion
	logic [CNT_W-1:0]   cnt_q;
	logic [NDIG_W-1:0]  ndig_q;   // digits still held in dig_q
	logic [15:0]        pre_q;    // prefix characters, next in top byte
	logic [1:0]         pre_n_q;
	logic               upper_q;
	logic               out_valid_q;
	ita_out_t           out_q;

	logic               accept;
	logic               cmd_ok;
	logic               is_dec;
	logic               can_push;
	logic               push;
	logic               skip_done;
	ita_out_t           push_word;
	logic [DEC_W-1:0]   low;
	logic [DEC_W-1:0]   neg_low;
	logic [BCD_DIGS*4-1:0] bcd_adj;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign low       = in_data.value[DEC_W-1:0];
	assign neg_low   = '0 - low;
	assign cmd_ok    = (in_data.command == CMD_SDEC) || (in_data.command == CMD_UDEC) ||
	                   (in_data.command == CMD_HEX_LO) || (in_data.command == CMD_HEX_UP) ||
	                   (in_data.command == CMD_PTR_LO) || (in_data.command == CMD_PTR_UP);
	assign is_dec    = (in_data.command == CMD_SDEC) || (in_data.command == CMD_UDEC);
	assign can_push  = !out_valid_q || out_ready;
	assign skip_done = (dig_q[VALUE_W-1 -: 4] != 4'd0) || (ndig_q == NDIG_W'(1));

	// Add-3 adjust on every BCD digit before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGS; i++) begin
			if (dig_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_ok) begin
					state_d = is_dec ? ST_CONV : ST_SKIP;
				end
			end
			ST_CONV: begin
				if (cnt_q == CNT_W'(DEC_W - 1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (skip_done) begin
					state_d = (pre_n_q != 2'd0) ? ST_PREFIX : ST_DIGITS;
				end
			end
			ST_PREFIX: begin
				if (can_push && pre_n_q == 2'd1) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (can_push && ndig_q == NDIG_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output word selection
	always_comb begin
		push      = 1'b0;
		push_word = '0;
		unique case (state_q)
			ST_PREFIX: begin
				push               = can_push;
				push_word.out_char = pre_q[15:8];
				push_word.last     = 1'b0;
			end
			ST_DIGITS: begin
				push               = can_push;
				push_word.out_char = nib_to_ascii(dig_q[VALUE_W-1 -: 4], upper_q);
				push_word.last     = (ndig_q == NDIG_W'(1));
			end
			default: begin
				push      = 1'b0;
				push_word = '0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_word;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_q   <= '0;
					ndig_q  <= NDIG_W'(NIBBLES);
					upper_q <= (in_data.command == CMD_HEX_UP) ||
					           (in_data.command == CMD_PTR_UP);
					// decimal starts from an empty BCD register
					if (is_dec) begin
						dig_q <= '0;
					end else begin
						dig_q <= in_data.value;
					end
					if (in_data.command == CMD_SDEC && low[DEC_W-1]) begin
						bin_q <= neg_low;
					end else begin
						bin_q <= low;
					end
					// sign or pointer prefix
					if (in_data.command == CMD_SDEC && low[DEC_W-1]) begin
						pre_q   <= {CH_MINUS, 8'h00};
						pre_n_q <= 2'd1;
					end else if ((in_data.command == CMD_SDEC && in_data.plus_flag &&
					              low != '0) ||
					             (in_data.command == CMD_UDEC && in_data.plus_flag)) begin
						pre_q   <= {CH_PLUS, 8'h00};
						pre_n_q <= 2'd1;
					end else if (in_data.command == CMD_PTR_LO ||
					             in_data.command == CMD_PTR_UP) begin
						pre_q   <= {CH_ZERO, CH_X};
						pre_n_q <= 2'd2;
					end else begin
						pre_q   <= '0;
						pre_n_q <= 2'd0;
					end
				end
			end
			ST_CONV: begin
				dig_q <= {{(VALUE_W - BCD_DIGS*4){1'b0}},
				          bcd_adj[BCD_DIGS*4-2:0], bin_q[DEC_W-1]};
				bin_q <= {bin_q[DEC_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_SKIP: begin
				if (!skip_done) begin
					dig_q  <= {dig_q[VALUE_W-5:0], 4'd0};
					ndig_q <= ndig_q - NDIG_W'(1);
				end
			end
			ST_PREFIX: begin
				if (push) begin
					pre_q   <= {pre_q[7:0], 8'h00};
					pre_n_q <= pre_n_q - 2'd1;
				end
			end
			ST_DIGITS: begin
				if (push) begin
					dig_q  <= {dig_q[VALUE_W-5:0], 4'd0};
					ndig_q <= ndig_q - NDIG_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_bad_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cmd_ok) |=> in_ready)
		else $error("unknown command left idle");
	a_digits_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (ndig_q != '0))
		else $error("digit count empty while emitting");
	a_prefix_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREFIX) |-> (pre_n_q != 2'd0))
		else $error("prefix count empty while emitting prefix");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_word.last) |=> (state_q == ST_IDLE))
		else $error("last character did not end the word");

endmodule
